/* rtl/apcp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ASCII pixel command parser.
// No dependencies; every other file of the block imports this package.
package apcp_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int DEF_PIXEL_COUNT   = 64;
  localparam int DEF_LINE_LENGTH   = 512;
  localparam int DEF_CHANNEL_COUNT = 2;

  // Bytes with a meaning at line level.
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Where a channel stands inside the integer it is reading.
  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_HEX0,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  // Parse state kept for each channel (the byte counter is held apart,
  // since its width follows the line length).
  typedef struct packed {
    logic [2:0]  field_number;
    phase_t      number_phase;
    logic        line_failed;
    logic        line_ended;
    logic        is_negative;
    base_t       number_base;
    logic [31:0] accumulator;
    logic [31:0] saved_index;
    logic [7:0]  saved_red;
    logic [7:0]  saved_green;
  } chan_state_t;

  localparam chan_state_t CHAN_RESET = '{
    field_number: 3'd0,
    number_phase: PH_SKIP,
    line_failed:  1'b0,
    line_ended:   1'b0,
    is_negative:  1'b0,
    number_base:  BASE_DEC,
    accumulator:  32'd0,
    saved_index:  32'd0,
    saved_red:    8'd0,
    saved_green:  8'd0
  };

  // One pixel write.
  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } pixel_wr_t;

endpackage

/* rtl/apcp_state_bank.sv */
`timescale 1ns / 1ps
// Per-channel parse state and byte counters, held in flip-flops.
// Depends on apcp_pkg for the channel state type.
module apcp_state_bank #(
  parameter int CHANNEL_COUNT = apcp_pkg::DEF_CHANNEL_COUNT,
  parameter int CH_IDX_W      = 1,
  parameter int CNT_W         = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [CH_IDX_W-1:0]       idx,
  output apcp_pkg::chan_state_t     rd_state,
  output logic [CNT_W-1:0]          rd_cnt,
  input  logic                      wr_en,
  input  apcp_pkg::chan_state_t     wr_state,
  input  logic [CNT_W-1:0]          wr_cnt
);
  import apcp_pkg::*;

  chan_state_t      state_r [CHANNEL_COUNT];
  logic [CNT_W-1:0] cnt_r   [CHANNEL_COUNT];

  assign rd_state = state_r[idx];
  assign rd_cnt   = cnt_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        state_r[i] <= CHAN_RESET;
        cnt_r[i]   <= '0;
      end
    end else if (wr_en) begin
      state_r[idx] <= wr_state;
      cnt_r[idx]   <= wr_cnt;
    end
  end

endmodule

/* rtl/apcp_parse.sv */
`timescale 1ns / 1ps
// Next-state logic of one channel for one received byte, and the pixel write
// decision at end of line. Depends on apcp_pkg.
module apcp_parse #(
  parameter int PIXEL_COUNT = apcp_pkg::DEF_PIXEL_COUNT,
  parameter int LINE_LENGTH = apcp_pkg::DEF_LINE_LENGTH,
  parameter int CNT_W       = 9
) (
  input  apcp_pkg::chan_state_t cur_state,
  input  logic [CNT_W-1:0]      cur_cnt,
  input  logic [7:0]            char_byte,
  output apcp_pkg::chan_state_t nxt_state,
  output logic [CNT_W-1:0]      nxt_cnt,
  output logic                  emit,
  output apcp_pkg::pixel_wr_t   pixel
);
  import apcp_pkg::*;

  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG1  = 8'h31;
  localparam logic [7:0] CH_DIG7  = 8'h37;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_DIG0) && (c <= CH_DIG9);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  // Letters a-f and A-F have low nibbles 1..6.
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return is_dec(c) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  // Close the current integer and file it under its field.
  function automatic chan_state_t finish_num(input chan_state_t s);
    chan_state_t n;
    logic [31:0] v;
    logic        last;
    n    = s;
    v    = s.is_negative ? (32'd0 - s.accumulator) : s.accumulator;
    last = (s.field_number >= 3'd3);
    unique case (s.field_number)
      3'd0:    n.saved_index = v;
      3'd1:    n.saved_red   = v[7:0];
      3'd2:    n.saved_green = v[7:0];
      default: ;
    endcase
    n.field_number = s.field_number + 3'd1;
    n.accumulator  = last ? v : 32'd0;
    n.is_negative  = 1'b0;
    n.number_base  = BASE_DEC;
    n.number_phase = last ? PH_DONE : PH_SKIP;
    return n;
  endfunction

  // A byte seen while looking for the start of an integer.
  function automatic chan_state_t start_num(input chan_state_t s, input logic [7:0] c);
    chan_state_t n;
    n = s;
    if ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR) && (c != CH_NEWLINE))) begin
      n = s;
    end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
      n.is_negative  = (c == CH_MINUS);
      n.number_phase = PH_SIGN;
    end else if (c == CH_DIG0) begin
      n.accumulator  = 32'd0;
      n.number_phase = PH_ZERO;
    end else if ((c >= CH_DIG1) && (c <= CH_DIG9)) begin
      n.accumulator  = {28'd0, c[3:0]};
      n.number_base  = BASE_DEC;
      n.number_phase = PH_DIGITS;
    end else begin
      n.line_failed = 1'b1;
    end
    return n;
  endfunction

  // A byte that ends the integer is also read as the start of the next.
  function automatic chan_state_t end_and_restart(input chan_state_t s, input logic [7:0] c);
    chan_state_t n;
    n = finish_num(s);
    if (n.number_phase == PH_SKIP) begin
      n = start_num(n, c);
    end
    return n;
  endfunction

  function automatic chan_state_t end_content(input chan_state_t s);
    chan_state_t n;
    n = s;
    if (!s.line_failed && !s.line_ended) begin
      if ((s.number_phase == PH_ZERO) || (s.number_phase == PH_DIGITS)) begin
        n = finish_num(s);
      end else if ((s.number_phase == PH_SIGN) || (s.number_phase == PH_HEX0)) begin
        n.line_failed = 1'b1;
      end
      n.line_ended = 1'b1;
    end
    return n;
  endfunction

  chan_state_t      parsed;
  chan_state_t      ended;
  logic [31:0]      acc_scaled;
  logic             in_radix;
  logic [CNT_W:0]   cnt_inc;

  // Accumulator times the radix, as shifts and one add.
  always_comb begin
    unique case (cur_state.number_base)
      BASE_OCT: begin
        acc_scaled = {cur_state.accumulator[28:0], 3'd0};
        in_radix   = (char_byte >= CH_DIG0) && (char_byte <= CH_DIG7);
      end
      BASE_HEX: begin
        acc_scaled = {cur_state.accumulator[27:0], 4'd0};
        in_radix   = is_hex(char_byte);
      end
      default: begin
        acc_scaled = {cur_state.accumulator[28:0], 3'd0} +
                     {cur_state.accumulator[30:0], 1'b0};
        in_radix   = is_dec(char_byte);
      end
    endcase
  end

  // Ordinary byte inside the line.
  always_comb begin
    parsed = cur_state;
    unique case (cur_state.number_phase)
      PH_SKIP: parsed = start_num(cur_state, char_byte);
      PH_SIGN: begin
        if (char_byte == CH_DIG0) begin
          parsed.accumulator  = 32'd0;
          parsed.number_phase = PH_ZERO;
        end else if ((char_byte >= CH_DIG1) && (char_byte <= CH_DIG9)) begin
          parsed.accumulator  = {28'd0, char_byte[3:0]};
          parsed.number_base  = BASE_DEC;
          parsed.number_phase = PH_DIGITS;
        end else begin
          parsed.line_failed = 1'b1;
        end
      end
      PH_ZERO: begin
        if ((char_byte == CH_LX) || (char_byte == CH_UX)) begin
          parsed.number_phase = PH_HEX0;
        end else if ((char_byte >= CH_DIG0) && (char_byte <= CH_DIG7)) begin
          parsed.accumulator  = {28'd0, char_byte[3:0]};
          parsed.number_base  = BASE_OCT;
          parsed.number_phase = PH_DIGITS;
        end else begin
          parsed = end_and_restart(cur_state, char_byte);
        end
      end
      PH_HEX0: begin
        if (is_hex(char_byte)) begin
          parsed.accumulator  = {28'd0, digit_val(char_byte)};
          parsed.number_base  = BASE_HEX;
          parsed.number_phase = PH_DIGITS;
        end else begin
          parsed.line_failed = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (in_radix) begin
          parsed.accumulator = acc_scaled + {28'd0, digit_val(char_byte)};
        end else begin
          parsed = end_and_restart(cur_state, char_byte);
        end
      end
      default: parsed = cur_state;
    endcase
  end

  assign ended   = end_content(cur_state);
  assign cnt_inc = {1'b0, cur_cnt} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    emit      = 1'b0;
    nxt_state = cur_state;
    nxt_cnt   = cur_cnt;
    if (char_byte == CH_NEWLINE) begin
      emit      = !ended.line_failed && (ended.field_number >= 3'd4) &&
                  (ended.saved_index < 32'(PIXEL_COUNT));
      nxt_state = CHAN_RESET;
      nxt_cnt   = '0;
    end else begin
      if (char_byte == CH_NUL) begin
        nxt_state = ended;
      end else if (!cur_state.line_failed && !cur_state.line_ended) begin
        nxt_state = parsed;
      end
      if (cnt_inc >= (CNT_W + 1)'(LINE_LENGTH)) begin
        nxt_state = CHAN_RESET;
        nxt_cnt   = '0;
      end else begin
        nxt_cnt = cnt_inc[CNT_W-1:0];
      end
    end
  end

  assign pixel.pixel_index = ended.saved_index[5:0];
  assign pixel.red_level   = ended.saved_red;
  assign pixel.green_level = ended.saved_green;
  assign pixel.blue_level  = ended.accumulator[7:0];

endmodule

/* rtl/ascii_pixel_command_parser_core.sv */
`timescale 1ns / 1ps
// ASCII pixel command parser, top level.
// A byte beat passes the input register and then the output register before its result beat shows.
// Throughput: one byte beat per cycle while the output register is free or being taken, also back
// to back on the same channel, since the channel state is read, updated and written back as it is processed.
// Reset (rst_n low, synchronous) empties the pipeline and returns every channel to a fresh line.
module ascii_pixel_command_parser_core #(
  parameter int PIXEL_COUNT   = apcp_pkg::DEF_PIXEL_COUNT,
  parameter int LINE_LENGTH   = apcp_pkg::DEF_LINE_LENGTH,
  parameter int CHANNEL_COUNT = apcp_pkg::DEF_CHANNEL_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Byte input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic [0:0]  in_tuser,   // [0] channel
  // Pixel write channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [5:0] pixel_index, [13:6] red_level,
                                  // [21:14] green_level, [29:22] blue_level, [31:30] zero
  output logic [0:0]  out_tuser   // [0] source_channel
);
  import apcp_pkg::*;

  localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CNT_W    = $clog2(LINE_LENGTH);

  // Input register: holds one byte beat while its channel state is updated.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_chan_r;
  logic [7:0] s1_byte_r;

  // Output register: holds a finished pixel write until the sink takes it;
  // while a result waits, no further byte is processed and the input side stalls.
  logic       out_valid_r, out_valid_nxt;
  logic       out_chan_r;
  pixel_wr_t  out_pixel_r;

  logic                  proc;
  logic                  chan_ok;
  logic [CH_IDX_W-1:0]   chan_idx;
  chan_state_t           cur_state, nxt_state;
  logic [CNT_W-1:0]      cur_cnt, nxt_cnt;
  logic                  emit;
  pixel_wr_t             pixel;

  // The buffered byte is processed whenever the output register is free or
  // is being emptied in this cycle; the input register refills in the same cycle.
  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;

  // Bytes of a channel number beyond the configured count are dropped.
  assign chan_ok  = (32'(s1_chan_r) < CHANNEL_COUNT);
  assign chan_idx = CH_IDX_W'(s1_chan_r);

  apcp_state_bank #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .CH_IDX_W      (CH_IDX_W),
    .CNT_W         (CNT_W)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .idx      (chan_idx),
    .rd_state (cur_state),
    .rd_cnt   (cur_cnt),
    .wr_en    (proc && chan_ok),
    .wr_state (nxt_state),
    .wr_cnt   (nxt_cnt)
  );

  apcp_parse #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .LINE_LENGTH (LINE_LENGTH),
    .CNT_W       (CNT_W)
  ) u_parse (
    .cur_state (cur_state),
    .cur_cnt   (cur_cnt),
    .char_byte (s1_byte_r),
    .nxt_state (nxt_state),
    .nxt_cnt   (nxt_cnt),
    .emit      (emit),
    .pixel     (pixel)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  // A processed byte always overwrites the output valid, because processing
  // only happens when the register is empty or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = emit && chan_ok;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_chan_r <= in_tuser[0];
      s1_byte_r <= in_tdata;
    end
    if (proc) begin
      out_chan_r  <= s1_chan_r;
      out_pixel_r <= pixel;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_chan_r;
  assign out_tdata    = {2'b00, out_pixel_r.blue_level, out_pixel_r.green_level,
                         out_pixel_r.red_level, out_pixel_r.pixel_index};

endmodule
